[hdl/blq_pkg.sv]
// Shared types, codes and constants for the button lockout and level qualifier.
// No dependencies; every other file of the block except blq_if.sv imports this package.
package blq_pkg;

   // Result event codes
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_UP     = 3'd1,
      EV_DOWN   = 3'd2,
      EV_LEFT   = 3'd3,
      EV_RIGHT  = 3'd4,
      EV_RESET  = 3'd5,
      EV_VOLUME = 3'd6
   } event_type;

   // Screen modes
   typedef enum logic [1:0] {
      MODE_SETTINGS = 2'd0,
      MODE_RESET    = 2'd1,
      MODE_VOLUME   = 2'd2
   } mode_type;

   // Register indexes on the CSR port
   localparam int unsigned CsrAddrWidth = 5;
   typedef enum logic [2:0] {
      REG_BUTTON_LOCKOUT = 3'd0,
      REG_LEVEL_STEP     = 3'd1,
      REG_GLITCH_BOUND   = 3'd2,
      REG_LEVEL_HOLD     = 3'd3,
      REG_MENU_COUNT     = 3'd4
   } reg_index_type;

   // Register reset values
   localparam logic [15:0] BUTTON_LOCKOUT_RESET = 16'd200;
   localparam logic [7:0]  LEVEL_STEP_RESET     = 8'd5;
   localparam logic [7:0]  GLITCH_BOUND_RESET   = 8'd20;
   localparam logic [15:0] LEVEL_HOLD_RESET     = 16'd400;
   localparam logic [7:0]  MENU_COUNT_RESET     = 8'd8;

   // Divide by five: floor(raw * 205 / 1024) is exact for raw below 1024
   localparam logic [17:0] DIV5_MUL   = 18'd205;
   localparam int unsigned DIV5_SHIFT = 10;

   // Snapping thresholds
   localparam logic [7:0] SNAP_MID_LOW  = 8'd95;
   localparam logic [7:0] SNAP_MID_HIGH = 8'd105;
   localparam logic [7:0] SNAP_MID      = 8'd100;
   localparam logic [7:0] SNAP_TOP_OVER = 8'd195;
   localparam logic [7:0] SNAP_TOP      = 8'd200;
   localparam logic [7:0] SNAP_BOT_BELOW = 8'd5;
   localparam logic [7:0] SNAP_BOT      = 8'd0;

   typedef struct packed {
      logic [15:0] button_lockout_ms;
      logic [7:0]  level_step;
      logic [7:0]  level_glitch_bound;
      logic [15:0] level_hold_ms;
      logic [7:0]  menu_count;
   } cfg_type;

   typedef struct packed {
      logic        up_pressed;
      logic        down_pressed;
      logic        left_pressed;
      logic        right_pressed;
      logic        reset_pressed;
      logic [9:0]  level_raw;
      logic [31:0] now_ms;
      logic        return_to_settings;
   } req_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  page_index;
      mode_type    mode;
      logic [7:0]  level;
   } rsp_type;

endpackage

[hdl/blq_if.sv]
// Valid/ready channel interfaces for poll words and result words.
// No dependencies.
interface blq_req_if;
   logic        valid;
   logic        ready;
   logic        up_pressed;
   logic        down_pressed;
   logic        left_pressed;
   logic        right_pressed;
   logic        reset_pressed;
   logic [9:0]  level_raw;
   logic [31:0] now_ms;
   logic        return_to_settings;

   modport source (
      output valid, up_pressed, down_pressed, left_pressed, right_pressed,
             reset_pressed, level_raw, now_ms, return_to_settings,
      input  ready
   );
   modport sink (
      input  valid, up_pressed, down_pressed, left_pressed, right_pressed,
             reset_pressed, level_raw, now_ms, return_to_settings,
      output ready
   );
endinterface

interface blq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] page_index;
   logic [1:0] mode;
   logic [7:0] level;

   modport source (
      output valid, event_res, page_index, mode, level,
      input  ready
   );
   modport sink (
      input  valid, event_res, page_index, mode, level,
      output ready
   );
endinterface

[hdl/blq_csr.sv]
// APB-style configuration registers of the qualifier.
// Depends on blq_pkg.
module blq_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [blq_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready,
   output blq_pkg::cfg_type                   cfg
);
   import blq_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_BUTTON_LOCKOUT: cfg_in.button_lockout_ms  = csr_pwdata[15:0];
            REG_LEVEL_STEP:     cfg_in.level_step         = csr_pwdata[7:0];
            REG_GLITCH_BOUND:   cfg_in.level_glitch_bound = csr_pwdata[7:0];
            REG_LEVEL_HOLD:     cfg_in.level_hold_ms      = csr_pwdata[15:0];
            REG_MENU_COUNT:     cfg_in.menu_count         = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_lockout_ms  <= BUTTON_LOCKOUT_RESET;
         cfg_ff.level_step         <= LEVEL_STEP_RESET;
         cfg_ff.level_glitch_bound <= GLITCH_BOUND_RESET;
         cfg_ff.level_hold_ms      <= LEVEL_HOLD_RESET;
         cfg_ff.menu_count         <= MENU_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read decode
   always_comb begin
      unique case (index)
         REG_BUTTON_LOCKOUT: csr_prdata = {16'd0, cfg_ff.button_lockout_ms};
         REG_LEVEL_STEP:     csr_prdata = {24'd0, cfg_ff.level_step};
         REG_GLITCH_BOUND:   csr_prdata = {24'd0, cfg_ff.level_glitch_bound};
         REG_LEVEL_HOLD:     csr_prdata = {16'd0, cfg_ff.level_hold_ms};
         REG_MENU_COUNT:     csr_prdata = {24'd0, cfg_ff.menu_count};
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

[hdl/blq_core.sv]
// Poll evaluation: button arbitration with lockouts, menu paging and level qualification.
// Holds the press stamps, page, mode and level state. Depends on blq_pkg.
module blq_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  blq_pkg::req_type  item,
   input  blq_pkg::cfg_type  cfg,
   output blq_pkg::rsp_type  result
);
   import blq_pkg::*;

   logic [31:0] up_time_ff, up_time_in;
   logic [31:0] down_time_ff, down_time_in;
   logic [31:0] left_time_ff, left_time_in;
   logic [31:0] right_time_ff, right_time_in;
   logic [31:0] reset_time_ff, reset_time_in;
   logic [31:0] any_time_ff, any_time_in;
   logic [7:0]  last_level_ff, last_level_in;
   logic        primed_ff, primed_in;
   logic [7:0]  page_ff, page_in;
   mode_type    mode_ff, mode_in;

   logic [17:0] div_prod;
   logic [7:0]  v;
   logic [7:0]  v_snap;
   logic [7:0]  diff;
   logic [7:0]  count_eff;
   logic [8:0]  page_inc;
   mode_type    mode_cur;
   logic        up_ok, down_ok, left_ok, right_ok, rst_ok, hold_ok;
   event_type   ev;

   // Stamp plus span, modulo 2^32, not later than now
   function automatic logic elapsed(input logic [31:0] stamp, input logic [15:0] span,
                                    input logic [31:0] now);
      logic [31:0] sum;
      sum = stamp + {16'd0, span};
      return sum <= now;
   endfunction

   // Level sample divided by five
   assign div_prod = {8'd0, item.level_raw} * DIV5_MUL;
   assign v        = div_prod[DIV5_SHIFT+7:DIV5_SHIFT];

   assign diff = (v >= last_level_ff) ? (v - last_level_ff) : (last_level_ff - v);

   always_comb begin
      if (v <= SNAP_MID_HIGH && v >= SNAP_MID_LOW) v_snap = SNAP_MID;
      else if (v > SNAP_TOP_OVER)                  v_snap = SNAP_TOP;
      else if (v < SNAP_BOT_BELOW)                 v_snap = SNAP_BOT;
      else                                         v_snap = v;
   end

   assign up_ok    = item.up_pressed    && elapsed(up_time_ff, cfg.button_lockout_ms, item.now_ms);
   assign down_ok  = item.down_pressed  && elapsed(down_time_ff, cfg.button_lockout_ms, item.now_ms);
   assign left_ok  = item.left_pressed  && elapsed(left_time_ff, cfg.button_lockout_ms, item.now_ms);
   assign right_ok = item.right_pressed && elapsed(right_time_ff, cfg.button_lockout_ms, item.now_ms);
   assign rst_ok   = item.reset_pressed && elapsed(reset_time_ff, cfg.button_lockout_ms, item.now_ms);
   assign hold_ok  = elapsed(any_time_ff, cfg.level_hold_ms, item.now_ms);

   // A zero page count behaves as one
   assign count_eff = (cfg.menu_count == 8'd0) ? 8'd1 : cfg.menu_count;
   assign page_inc  = {1'b0, page_ff} + 9'd1;
   assign mode_cur  = item.return_to_settings ? MODE_SETTINGS : mode_ff;

   // Next state, first winning button in fixed priority order
   always_comb begin
      up_time_in    = up_time_ff;
      down_time_in  = down_time_ff;
      left_time_in  = left_time_ff;
      right_time_in = right_time_ff;
      reset_time_in = reset_time_ff;
      any_time_in   = any_time_ff;
      last_level_in = last_level_ff;
      primed_in     = primed_ff;
      page_in       = page_ff;
      mode_in       = mode_cur;
      ev            = EV_NONE;

      if (!primed_ff) begin
         last_level_in = v;
         primed_in     = 1'b1;
      end else if (up_ok) begin
         if (mode_cur == MODE_SETTINGS) begin
            up_time_in  = item.now_ms;
            any_time_in = item.now_ms;
            ev          = EV_UP;
         end
      end else if (down_ok) begin
         if (mode_cur == MODE_SETTINGS) begin
            down_time_in = item.now_ms;
            any_time_in  = item.now_ms;
            ev           = EV_DOWN;
         end
      end else if (left_ok) begin
         left_time_in = item.now_ms;
         any_time_in  = item.now_ms;
         page_in      = (page_ff == 8'd0) ? (count_eff - 8'd1) : (page_ff - 8'd1);
         mode_in      = MODE_SETTINGS;
         ev           = EV_LEFT;
      end else if (right_ok) begin
         right_time_in = item.now_ms;
         any_time_in   = item.now_ms;
         page_in       = (page_inc >= {1'b0, count_eff}) ? 8'd0 : page_inc[7:0];
         mode_in       = MODE_SETTINGS;
         ev            = EV_RIGHT;
      end else if (rst_ok) begin
         reset_time_in = item.now_ms;
         mode_in       = MODE_RESET;
         ev            = EV_RESET;
      end else if (diff >= cfg.level_step && diff < cfg.level_glitch_bound && hold_ok) begin
         last_level_in = v_snap;
         mode_in       = MODE_VOLUME;
         ev            = EV_VOLUME;
      end
   end

   // State updates only on a poll that moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         up_time_ff    <= 32'd0;
         down_time_ff  <= 32'd0;
         left_time_ff  <= 32'd0;
         right_time_ff <= 32'd0;
         reset_time_ff <= 32'd0;
         any_time_ff   <= 32'd0;
         last_level_ff <= 8'd0;
         primed_ff     <= 1'b0;
         page_ff       <= 8'd0;
         mode_ff       <= MODE_SETTINGS;
      end else if (fire) begin
         up_time_ff    <= up_time_in;
         down_time_ff  <= down_time_in;
         left_time_ff  <= left_time_in;
         right_time_ff <= right_time_in;
         reset_time_ff <= reset_time_in;
         any_time_ff   <= any_time_in;
         last_level_ff <= last_level_in;
         primed_ff     <= primed_in;
         page_ff       <= page_in;
         mode_ff       <= mode_in;
      end
   end

   assign result.event_res  = ev;
   assign result.page_index = page_in;
   assign result.mode       = mode_in;
   assign result.level      = last_level_in;
endmodule

[hdl/button_lockout_level_qualifier.sv]
// Button lockout and level qualifier: one poll word in, one result word out per poll.
// A poll is captured in an input register and evaluated combinationally; the result
// waits in an output register. Throughput is one poll per clock cycle while the output
// is free. The result word is registered on the edge at which the poll leaves the input
// register, and the state registers of the poll evaluator update on that same edge
// (arbitration, page step and level check feed them directly). Both registers advance
// together whenever the output is empty or being taken.
// Configuration registers sit on the CSR port at byte addresses 0, 4, 8, 12 and 16.
module button_lockout_level_qualifier (
   input  logic                              clock,
   input  logic                              reset,
   blq_req_if.sink                           req_port,
   blq_rsp_if.source                         rsp_port,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [blq_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import blq_pkg::*;

   cfg_type cfg;
   req_type in_word;
   req_type s0_word_ff;
   logic    s0_valid_ff, s0_valid_in;
   rsp_type rsp_word_ff;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    advance;

   blq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gather the incoming word
   assign in_word.up_pressed         = req_port.up_pressed;
   assign in_word.down_pressed       = req_port.down_pressed;
   assign in_word.left_pressed       = req_port.left_pressed;
   assign in_word.right_pressed      = req_port.right_pressed;
   assign in_word.reset_pressed      = req_port.reset_pressed;
   assign in_word.level_raw          = req_port.level_raw;
   assign in_word.now_ms             = req_port.now_ms;
   assign in_word.return_to_settings = req_port.return_to_settings;

   // Flow control between input and output registers
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign advance        = s0_valid_ff && out_free;
   assign req_port.ready = !s0_valid_ff || advance;
   assign s0_valid_in    = req_port.valid ? 1'b1 : (s0_valid_ff && !advance);
   assign rsp_valid_in   = advance ? 1'b1 : (rsp_valid_ff && !rsp_port.ready);

   blq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (s0_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= req_port.ready ? s0_valid_in : s0_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         s0_word_ff <= in_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.event_res  = rsp_word_ff.event_res;
   assign rsp_port.page_index = rsp_word_ff.page_index;
   assign rsp_port.mode       = rsp_word_ff.mode;
   assign rsp_port.level      = rsp_word_ff.level;
endmodule

[tb/poll_outcome_checker.sv]
`timescale 1ns / 1ps
// Checker for the button lockout and level qualifier: watches the poll and result
// channels and the CSR port, predicts each result word and compares it field by field.
// Depends on blq_pkg and the channel interfaces in blq_if.sv.
module poll_outcome_checker (
   input  logic                              clock,
   input  logic                              reset,
   blq_req_if                                req_mon,
   blq_rsp_if                                rsp_mon,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [blq_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   input  logic                              csr_pready,
   output int unsigned                       pending_words,
   output int unsigned                       mismatch_count
);
   import blq_pkg::*;

   // Shadow configuration
   logic [15:0] lockout_ms;
   logic [7:0]  step_min;
   logic [7:0]  glitch_max;
   logic [15:0] hold_ms;
   logic [7:0]  page_count;

   // Shadow state of the qualifier
   logic [31:0] up_stamp, down_stamp, left_stamp, right_stamp, clear_stamp;
   logic [31:0] menu_stamp;
   logic [7:0]  level_now;
   logic        primed_flag;
   logic [7:0]  page_now;
   mode_type    mode_now;

   rsp_type     pending_outcomes[$];

   initial begin
      pending_words  = 0;
      mismatch_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Wrapping deadline test, shared by lockout and hold
   function automatic logic out_of_window(input logic [31:0] stamp, input logic [31:0] span,
                                          input logic [31:0] now);
      logic [31:0] due;
      due = stamp + span;
      return due <= now;
   endfunction

   // Works out the result word of one poll and advances the shadow state
   function automatic rsp_type qualify_poll(input req_type p);
      rsp_type     r;
      event_type   ev;
      logic [7:0]  v;
      logic [7:0]  diff;
      logic [7:0]  pages;
      ev    = EV_NONE;
      v     = 8'(p.level_raw / 10'd5);
      pages = (page_count == 8'd0) ? 8'd1 : page_count;
      if (p.return_to_settings)
         mode_now = MODE_SETTINGS;
      if (!primed_flag) begin
         level_now   = v;
         primed_flag = 1'b1;
      end else if (p.up_pressed && out_of_window(up_stamp, 32'(lockout_ms), p.now_ms)) begin
         if (mode_now == MODE_SETTINGS) begin
            up_stamp   = p.now_ms;
            menu_stamp = p.now_ms;
            ev         = EV_UP;
         end
      end else if (p.down_pressed && out_of_window(down_stamp, 32'(lockout_ms), p.now_ms)) begin
         if (mode_now == MODE_SETTINGS) begin
            down_stamp = p.now_ms;
            menu_stamp = p.now_ms;
            ev         = EV_DOWN;
         end
      end else if (p.left_pressed && out_of_window(left_stamp, 32'(lockout_ms), p.now_ms)) begin
         left_stamp = p.now_ms;
         menu_stamp = p.now_ms;
         page_now   = (page_now == 8'd0) ? pages - 8'd1 : page_now - 8'd1;
         mode_now   = MODE_SETTINGS;
         ev         = EV_LEFT;
      end else if (p.right_pressed && out_of_window(right_stamp, 32'(lockout_ms), p.now_ms))
      begin
         right_stamp = p.now_ms;
         menu_stamp  = p.now_ms;
         // stale page above the count wraps straight to 0
         page_now    = ({1'b0, page_now} + 9'd1 >= {1'b0, pages}) ? 8'd0 : page_now + 8'd1;
         mode_now    = MODE_SETTINGS;
         ev          = EV_RIGHT;
      end else if (p.reset_pressed && out_of_window(clear_stamp, 32'(lockout_ms), p.now_ms))
      begin
         clear_stamp = p.now_ms;
         mode_now    = MODE_RESET;
         ev          = EV_RESET;
      end else begin
         diff = (v >= level_now) ? v - level_now : level_now - v;
         if (diff >= step_min && diff < glitch_max &&
             out_of_window(menu_stamp, 32'(hold_ms), p.now_ms)) begin
            if (v <= SNAP_MID_HIGH && v >= SNAP_MID_LOW)
               v = SNAP_MID;
            else if (v > SNAP_TOP_OVER)
               v = SNAP_TOP;
            else if (v < SNAP_BOT_BELOW)
               v = SNAP_BOT;
            level_now = v;
            mode_now  = MODE_VOLUME;
            ev        = EV_VOLUME;
         end
      end
      r.event_res  = ev;
      r.page_index = page_now;
      r.mode       = mode_now;
      r.level      = level_now;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      req_type poll;
      if (reset) begin
         lockout_ms  = BUTTON_LOCKOUT_RESET;
         step_min    = LEVEL_STEP_RESET;
         glitch_max  = GLITCH_BOUND_RESET;
         hold_ms     = LEVEL_HOLD_RESET;
         page_count  = MENU_COUNT_RESET;
         up_stamp    = '0;
         down_stamp  = '0;
         left_stamp  = '0;
         right_stamp = '0;
         clear_stamp = '0;
         menu_stamp  = '0;
         level_now   = '0;
         primed_flag = 1'b0;
         page_now    = '0;
         mode_now    = MODE_SETTINGS;
         pending_outcomes.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_BUTTON_LOCKOUT: lockout_ms = csr_pwdata[15:0];
               REG_LEVEL_STEP:     step_min   = csr_pwdata[7:0];
               REG_GLITCH_BOUND:   glitch_max = csr_pwdata[7:0];
               REG_LEVEL_HOLD:     hold_ms    = csr_pwdata[15:0];
               REG_MENU_COUNT:     page_count = csr_pwdata[7:0];
               default: ;
            endcase
         end

         // result words against the oldest expectation
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result word with nothing expected",
                               32'(rsp_mon.event_res), 32'(EV_NONE));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_mon.event_res !== want.event_res)
                  report_mismatch("event_res", 32'(rsp_mon.event_res), 32'(want.event_res));
               if (rsp_mon.page_index !== want.page_index)
                  report_mismatch("page_index", 32'(rsp_mon.page_index), 32'(want.page_index));
               if (rsp_mon.mode !== want.mode)
                  report_mismatch("mode", 32'(rsp_mon.mode), 32'(want.mode));
               if (rsp_mon.level !== want.level)
                  report_mismatch("level", 32'(rsp_mon.level), 32'(want.level));
            end
         end

         // poll words
         if (req_mon.valid && req_mon.ready) begin
            poll.up_pressed         = req_mon.up_pressed;
            poll.down_pressed       = req_mon.down_pressed;
            poll.left_pressed       = req_mon.left_pressed;
            poll.right_pressed      = req_mon.right_pressed;
            poll.reset_pressed      = req_mon.reset_pressed;
            poll.level_raw          = req_mon.level_raw;
            poll.now_ms             = req_mon.now_ms;
            poll.return_to_settings = req_mon.return_to_settings;
            pending_outcomes.push_back(qualify_poll(poll));
         end
      end
      pending_words <= pending_outcomes.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the button lockout and level qualifier testbench: clock, reset, poll stimulus,
// result-side back-pressure, CSR writes and the verdict. Depends on blq_pkg, blq_if.sv,
// poll_outcome_checker and the block itself.
module testbench;
   import blq_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   // key masks, ordered {up, down, left, right, reset}
   localparam logic [4:0] KEY_NONE  = 5'b00000;
   localparam logic [4:0] KEY_UP    = 5'b10000;
   localparam logic [4:0] KEY_DOWN  = 5'b01000;
   localparam logic [4:0] KEY_LEFT  = 5'b00100;
   localparam logic [4:0] KEY_RIGHT = 5'b00010;
   localparam logic [4:0] KEY_RESET = 5'b00001;
   localparam logic [4:0] KEY_ALL   = 5'b11111;

   logic clock;
   logic reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   int unsigned pending_words;
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   bit          hold_off_request;

   logic [31:0] wall_ms;
   int          knob_raw;

   blq_req_if req_bus ();
   blq_rsp_if rsp_bus ();

   button_lockout_level_qualifier DUT (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   poll_outcome_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_poll(input logic [4:0] keys, input int unsigned raw,
                                         input logic [31:0] stamp, input logic to_settings);
      req_type p;
      p.up_pressed         = keys[4];
      p.down_pressed       = keys[3];
      p.left_pressed       = keys[2];
      p.right_pressed      = keys[1];
      p.reset_pressed      = keys[0];
      p.level_raw          = 10'(raw);
      p.now_ms             = stamp;
      p.return_to_settings = to_settings;
      return p;
   endfunction

   // Offers one poll word after an optional gap and waits for it to be taken
   task automatic send_poll(input req_type p, input int unsigned gap);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.up_pressed         <= p.up_pressed;
      req_bus.down_pressed       <= p.down_pressed;
      req_bus.left_pressed       <= p.left_pressed;
      req_bus.right_pressed      <= p.right_pressed;
      req_bus.reset_pressed      <= p.reset_pressed;
      req_bus.level_raw          <= p.level_raw;
      req_bus.now_ms             <= p.now_ms;
      req_bus.return_to_settings <= p.return_to_settings;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops offering and waits until every expected result word is out
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] lockout, input logic [7:0] step,
                                 input logic [7:0] glitch, input logic [15:0] hold,
                                 input logic [7:0] pages);
      wait_drained();
      csr_write(REG_BUTTON_LOCKOUT, 32'(lockout));
      csr_write(REG_LEVEL_STEP, 32'(step));
      csr_write(REG_GLITCH_BOUND, 32'(glitch));
      csr_write(REG_LEVEL_HOLD, 32'(hold));
      csr_write(REG_MENU_COUNT, 32'(pages));
   endtask

   // Knob drifts mostly in small moves, time mostly advances; both jump now and then
   task automatic random_polls(input int unsigned count, input bit with_hold_off,
                               input bit with_drain_pause);
      int unsigned r;
      logic [4:0]  keys;
      int unsigned gap;
      for (int unsigned n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 70)
            wall_ms += $urandom_range(0, 60);
         else if (r < 96)
            wall_ms += $urandom_range(61, 700);
         else
            wall_ms = $urandom();

         r = $urandom_range(0, 99);
         if (r < 60)
            knob_raw += int'($urandom_range(0, 60)) - 30;
         else if (r < 85)
            knob_raw += int'($urandom_range(0, 300)) - 150;
         else if (r < 95)
            knob_raw = int'($urandom_range(0, 1023));
         if (knob_raw < 0)
            knob_raw = 0;
         else if (knob_raw > 1023)
            knob_raw = 1023;

         r = $urandom_range(0, 99);
         if (r < 55)
            keys = KEY_NONE;
         else if (r < 90)
            keys = KEY_RESET << $urandom_range(0, 4);
         else
            keys = 5'($urandom());

         if (with_hold_off && n == 60)
            hold_off_request = 1'b1;
         if (with_drain_pause && n == 100)
            wait_drained();

         gap = (n % 100 < 25) ? 0 : pick_gap();
         send_poll(make_poll(keys, knob_raw, wall_ms, $urandom_range(0, 9) == 0), gap);
      end
   endtask

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall;
      int unsigned burst;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
         repeat (burst) @(posedge clock);
      end
   end

   // Watchdog on cycles without any word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      reset                      = 1'b1;
      hold_off_request           = 1'b0;
      idle_cycles                = 0;
      csr_psel                   = 1'b0;
      csr_penable                = 1'b0;
      csr_pwrite                 = 1'b0;
      csr_paddr                  = '0;
      csr_pwdata                 = '0;
      req_bus.valid              = 1'b0;
      req_bus.up_pressed         = 1'b0;
      req_bus.down_pressed       = 1'b0;
      req_bus.left_pressed       = 1'b0;
      req_bus.right_pressed      = 1'b0;
      req_bus.reset_pressed      = 1'b0;
      req_bus.level_raw          = '0;
      req_bus.now_ms             = '0;
      req_bus.return_to_settings = 1'b0;
      wall_ms                    = 32'd5000;
      knob_raw                   = 512;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // priming poll ignores every button
      send_poll(make_poll(KEY_ALL, 1023, 32'd0, 1'b1), pick_gap());
      // glitch, under step, plain accept, accept snapped to top
      send_poll(make_poll(KEY_NONE, 500, 32'd1000, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 1000, 32'd1010, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 960, 32'd1020, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 1005, 32'd1030, 1'b0), pick_gap());
      // up and down win but do nothing outside settings
      send_poll(make_poll(KEY_UP, 1005, 32'd1040, 1'b0), pick_gap());
      send_poll(make_poll(KEY_DOWN, 1005, 32'd1050, 1'b0), pick_gap());
      send_poll(make_poll(KEY_UP, 1005, 32'd1060, 1'b1), pick_gap());
      // up locked out, so down takes the poll
      send_poll(make_poll(KEY_UP | KEY_DOWN, 1005, 32'd1100, 1'b0), pick_gap());
      // left from page 0 wraps to the top, right wraps back
      send_poll(make_poll(KEY_LEFT, 1005, 32'd1110, 1'b0), pick_gap());
      send_poll(make_poll(KEY_RIGHT, 1005, 32'd1120, 1'b0), pick_gap());
      send_poll(make_poll(KEY_RESET, 1005, 32'd1130, 1'b0), pick_gap());
      // level ignored within the hold time, then taken
      send_poll(make_poll(KEY_NONE, 925, 32'd1200, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 925, 32'd1600, 1'b0), pick_gap());
      // lockout deadline wrapping past the top of the time range
      send_poll(make_poll(KEY_RIGHT, 925, 32'hFFFF_FF80, 1'b0), pick_gap());
      send_poll(make_poll(KEY_RIGHT, 925, 32'h0000_0010, 1'b0), pick_gap());
      send_poll(make_poll(KEY_RIGHT, 925, 32'hFFFF_FFFF, 1'b0), pick_gap());

      // wide glitch bound to reach every snap band
      wait_drained();
      csr_write(REG_GLITCH_BOUND, 32'd255);
      send_poll(make_poll(KEY_NONE, 490, 32'd2000, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 25, 32'd2010, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 475, 32'd2020, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 975, 32'd2030, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 10, 32'd2040, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 525, 32'd2050, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 1023, 32'd2060, 1'b0), pick_gap());
      send_poll(make_poll(KEY_NONE, 0, 32'd2070, 1'b0), pick_gap());

      // random phases, each under its own settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: apply_settings(BUTTON_LOCKOUT_RESET, LEVEL_STEP_RESET, GLITCH_BOUND_RESET,
                              LEVEL_HOLD_RESET, MENU_COUNT_RESET);
            1: apply_settings(16'd0, 8'd0, 8'd255, 16'd0, 8'd255);
            // single page leaves any earlier page stale
            2: apply_settings(16'hFFFF, 8'd255, 8'd0, 16'hFFFF, 8'd1);
            // zero pages behaves as one
            3: apply_settings(16'd50, 8'd3, 8'd30, 16'd100, 8'd0);
            4: apply_settings(16'd150, 8'd1, 8'd12, 16'd300, 8'd5);
            default: apply_settings(16'($urandom_range(0, 400)), 8'($urandom_range(0, 10)),
                                    8'($urandom_range(5, 60)), 16'($urandom_range(0, 800)),
                                    8'($urandom_range(0, 255)));
         endcase
         random_polls(195, ph == 1, ph == 3);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
